/* rtl/srg_pkg.sv */
`default_nettype none

package srg_pkg;

	// modulus of the lagged subtraction and seed folding base
	localparam logic [29:0] MODULUS   = 30'd1000000000;
	localparam logic [31:0] SEED_BASE = 32'd161803398;

	// table geometry: words live at addresses 1..TABLE_LEN, address 0 unused
	localparam int          TABLE_DEPTH = 56;
	localparam logic [5:0]  TABLE_LEN   = 6'd55;
	localparam logic [5:0]  TRAIL_START = 6'd31;
	localparam logic [5:0]  SPREAD_STEP = 6'd21;
	localparam logic [5:0]  MIX_OFFSET  = 6'd31;
	localparam logic [5:0]  FILL_STEPS  = 6'd54;
	localparam logic [1:0]  LAST_PASS   = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_ABS,
		ST_SEED_DIFF,
		ST_SEED_WR,
		ST_FILL,
		ST_MIX_RD,
		ST_MIX_WR,
		ST_DRAW_RD,
		ST_DRAW_WR,
		ST_HOLD
	} srg_state_t;

	// (a - b) mod 1e9 for a, b below the modulus
	function automatic logic [29:0] sub_mod(input logic [29:0] a, input logic [29:0] b);
		logic [30:0] d;
		begin
			d = {1'b0, a} - {1'b0, b};
			if (d[30]) begin
				sub_mod = d[29:0] + MODULUS;
			end else begin
				sub_mod = d[29:0];
			end
		end
	endfunction

	// step an index through 1..55 with wrap to 1
	function automatic logic [5:0] advance(input logic [5:0] idx);
		begin
			if (idx >= TABLE_LEN) begin
				advance = 6'd1;
			end else begin
				advance = idx + 6'd1;
			end
		end
	endfunction

	// mixing partner of word i: 1 + (i + 30) mod 55
	function automatic logic [5:0] partner(input logic [5:0] i);
		logic [6:0] j;
		begin
			j = {1'b0, i} + {1'b0, MIX_OFFSET};
			if (j > {1'b0, TABLE_LEN}) begin
				j = j - {1'b0, TABLE_LEN};
			end
			partner = j[5:0];
		end
	endfunction

	// next spread-fill position: (pos + 21) mod 55
	function automatic logic [5:0] spread_next(input logic [5:0] pos);
		logic [6:0] j;
		begin
			j = {1'b0, pos} + {1'b0, SPREAD_STEP};
			if (j >= {1'b0, TABLE_LEN}) begin
				j = j - {1'b0, TABLE_LEN};
			end
			spread_next = j[5:0];
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/subtractive_random_generator.sv */
// Subtractive lagged random generator, modulus 1e9, 55-word table.
// Request channel: req_valid / req_stall with the reseed bit; each accepted
// word asks for one draw. Response channel: rsp_valid / rsp_stall with value,
// an integer in 1..999999999 (the uniform number is value / 1e9).
// Configuration: seed is written at any edge with seed_we high; it only takes
// effect at the next table rebuild.
// Steady draws: the two table words are read as the request is taken and the
// result is registered from the write-back state; the next request waits for
// its load into the output. Each draw is one read of two table words followed
// by one write-back through the single-write-port memory; zero draws repeat.
// The first request after reset, or one with reseed set, rebuilds the table
// first: seed folding, 54 fill writes and 4 x 55 mixing steps of one read and
// one write-back each, all before the draw.
// Reset clears the control state and marks the table as not built; the table
// contents themselves are not cleared.
// While the response is stalled the finished value is held (an output register
// plus one holding register), and the next request is taken once it is parked.
`default_nettype none

module subtractive_random_generator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               seed_we,
	input  wire logic signed [31:0] seed,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic               reseed,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic [29:0]             value
);

	srg_pkg::srg_state_t state_q, state_d;

	logic signed [31:0] seed_q;
	logic [5:0]  lead_q, trail_q;
	logic        ready_q;
	logic [31:0] mag_q, fold_q;
	logic [29:0] cur_q, prev_q, res_q;
	logic [5:0]  pos_q, cnt_q, mix_i_q;
	logic [1:0]  pass_q;
	logic        rsp_valid_q;
	logic [29:0] value_q;

	// table memory, two registered read ports and one write port
	logic [29:0] mem [srg_pkg::TABLE_DEPTH];
	logic [29:0] rd_a_q, rd_b_q;
	logic [5:0]  raddr_a, raddr_b, waddr;
	logic [29:0] wdata;
	logic        mem_we;

	logic        accept, rebuild, slot_free, out_load;
	logic [29:0] rd_diff, seed_mod, out_data;

	assign accept    = req_valid && !req_stall;
	assign rebuild   = reseed || !ready_q;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign rd_diff   = srg_pkg::sub_mod(rd_a_q, rd_b_q);
	assign seed_mod  = (fold_q >= {2'b00, srg_pkg::MODULUS}) ?
		30'(fold_q - {2'b00, srg_pkg::MODULUS}) : fold_q[29:0];

	assign req_stall = (state_q != srg_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign value     = value_q;

	// seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (seed_we) begin
			seed_q <= seed;
		end
	end

	// table storage
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[raddr_b];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory access and output load
	always_comb begin
		state_d  = state_q;
		mem_we   = 1'b0;
		waddr    = lead_q;
		wdata    = rd_diff;
		raddr_a  = srg_pkg::advance(lead_q);
		raddr_b  = srg_pkg::advance(trail_q);
		out_load = 1'b0;
		out_data = rd_diff;
		case (state_q)
			srg_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = rebuild ? srg_pkg::ST_SEED_ABS : srg_pkg::ST_DRAW_WR;
				end
			end
			srg_pkg::ST_SEED_ABS: begin
				state_d = srg_pkg::ST_SEED_DIFF;
			end
			srg_pkg::ST_SEED_DIFF: begin
				state_d = srg_pkg::ST_SEED_WR;
			end
			srg_pkg::ST_SEED_WR: begin
				mem_we  = 1'b1;
				waddr   = srg_pkg::TABLE_LEN;
				wdata   = seed_mod;
				state_d = srg_pkg::ST_FILL;
			end
			srg_pkg::ST_FILL: begin
				mem_we = 1'b1;
				waddr  = pos_q;
				wdata  = prev_q;
				if (cnt_q == srg_pkg::FILL_STEPS) begin
					state_d = srg_pkg::ST_MIX_RD;
				end
			end
			srg_pkg::ST_MIX_RD: begin
				raddr_a = mix_i_q;
				raddr_b = srg_pkg::partner(mix_i_q);
				state_d = srg_pkg::ST_MIX_WR;
			end
			srg_pkg::ST_MIX_WR: begin
				mem_we = 1'b1;
				waddr  = mix_i_q;
				if (mix_i_q == srg_pkg::TABLE_LEN && pass_q == srg_pkg::LAST_PASS) begin
					state_d = srg_pkg::ST_DRAW_RD;
				end else begin
					state_d = srg_pkg::ST_MIX_RD;
				end
			end
			srg_pkg::ST_DRAW_RD: begin
				state_d = srg_pkg::ST_DRAW_WR;
			end
			srg_pkg::ST_DRAW_WR: begin
				mem_we = 1'b1;
				waddr  = lead_q;
				if (rd_diff == '0) begin
					state_d = srg_pkg::ST_DRAW_RD;
				end else if (slot_free) begin
					out_load = 1'b1;
					state_d  = srg_pkg::ST_IDLE;
				end else begin
					state_d = srg_pkg::ST_HOLD;
				end
			end
			srg_pkg::ST_HOLD: begin
				out_data = res_q;
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = srg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = srg_pkg::ST_IDLE;
			end
		endcase
	end

	// indices, build counters and ready flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q  <= '0;
			trail_q <= srg_pkg::TRAIL_START;
			ready_q <= 1'b0;
			pos_q   <= '0;
			cnt_q   <= '0;
			mix_i_q <= '0;
			pass_q  <= '0;
		end else begin
			case (state_q)
				srg_pkg::ST_IDLE: begin
					if (accept && !rebuild) begin
						lead_q  <= srg_pkg::advance(lead_q);
						trail_q <= srg_pkg::advance(trail_q);
					end
				end
				srg_pkg::ST_SEED_WR: begin
					pos_q <= srg_pkg::SPREAD_STEP;
					cnt_q <= 6'd1;
				end
				srg_pkg::ST_FILL: begin
					pos_q <= srg_pkg::spread_next(pos_q);
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == srg_pkg::FILL_STEPS) begin
						mix_i_q <= 6'd1;
						pass_q  <= '0;
					end
				end
				srg_pkg::ST_MIX_WR: begin
					mix_i_q <= srg_pkg::advance(mix_i_q);
					if (mix_i_q == srg_pkg::TABLE_LEN) begin
						pass_q <= pass_q + 2'd1;
						if (pass_q == srg_pkg::LAST_PASS) begin
							lead_q  <= '0;
							trail_q <= srg_pkg::TRAIL_START;
							ready_q <= 1'b1;
						end
					end
				end
				srg_pkg::ST_DRAW_RD: begin
					lead_q  <= srg_pkg::advance(lead_q);
					trail_q <= srg_pkg::advance(trail_q);
				end
				default: begin
				end
			endcase
		end
	end

	// seed folding, fill recurrence and parked result
	always_ff @(posedge clk) begin
		case (state_q)
			srg_pkg::ST_SEED_ABS: begin
				mag_q <= seed_q[31] ? 32'(-seed_q) : 32'(seed_q);
			end
			srg_pkg::ST_SEED_DIFF: begin
				fold_q <= (mag_q > srg_pkg::SEED_BASE) ?
					mag_q - srg_pkg::SEED_BASE : srg_pkg::SEED_BASE - mag_q;
			end
			srg_pkg::ST_SEED_WR: begin
				cur_q  <= seed_mod;
				prev_q <= 30'd1;
			end
			srg_pkg::ST_FILL: begin
				prev_q <= srg_pkg::sub_mod(cur_q, prev_q);
				cur_q  <= prev_q;
			end
			srg_pkg::ST_DRAW_WR: begin
				res_q <= rd_diff;
			end
			default: begin
			end
		endcase
	end

	// response output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q <= out_data;
		end
	end

	// a zero draw never leaves the block, and values stay below the modulus
	a_rsp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (value != '0 && value < srg_pkg::MODULUS))
		else $error("response word out of range");

	// a taken request closes the request channel until its draw is parked
	a_req_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while previous draw in flight");

	// table writes only touch addresses 1..55
	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (waddr != '0 && waddr <= srg_pkg::TABLE_LEN))
		else $error("table write outside 1..55");

	// a draw only runs on a built table
	a_draw_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srg_pkg::ST_DRAW_WR) |-> ready_q)
		else $error("draw on unbuilt table");

endmodule

`default_nettype wire

/* bench/tb_subtractive_random_generator.sv */
`default_nettype none

module tb_subtractive_random_generator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MOD_INT      = int'(srg_pkg::MODULUS);
	localparam int LEN_INT      = int'(srg_pkg::TABLE_LEN);
	localparam int N_DIRECTED   = 16;
	localparam int N_PHASES     = 8;
	localparam int PHASE_WORDS  = 160;
	localparam int LONG_HOLD    = 1200;
	localparam int TAIL_CYCLES  = 40;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               seed_we   = 1'b0;
	logic signed [31:0] seed      = '0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic               reseed    = 1'b0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [29:0]        value;

	subtractive_random_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_we   (seed_we),
		.seed      (seed),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.reseed    (reseed),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.value     (value)
	);

	// directed stimulus rows
	typedef struct {
		bit                 load_seed;
		logic signed [31:0] seed_val;
		bit                 reseed_bit;
	} draw_row_t;

	draw_row_t directed_rows [N_DIRECTED] = '{
		'{1'b0, 32'sd0, 1'b0},            // first draw after reset, reset seed
		'{1'b0, 32'sd0, 1'b0},
		'{1'b0, 32'sd0, 1'b0},
		'{1'b0, 32'sd0, 1'b1},            // rebuild with same seed restarts sequence
		'{1'b0, 32'sd0, 1'b0},
		'{1'b1, 32'sh7fffffff, 1'b0},     // seed write alone keeps the table
		'{1'b0, 32'sd0, 1'b1},            // rebuild from largest seed
		'{1'b0, 32'sd0, 1'b0},
		'{1'b1, 32'sh80000000, 1'b1},     // most negative seed
		'{1'b0, 32'sd0, 1'b0},
		'{1'b1, 32'sd161803398, 1'b1},    // folded first word is zero
		'{1'b0, 32'sd0, 1'b0},
		'{1'b1, -32'sd161803398, 1'b1},
		'{1'b1, 32'sd1, 1'b1},
		'{1'b1, -32'sd1, 1'b1},
		'{1'b1, 32'sd0, 1'b0}
	};

	// predictor state
	int                 lag_words [0:55];
	logic [5:0]         lead_pos;
	logic [5:0]         trail_pos;
	bit                 table_built;
	logic signed [31:0] seed_reg;

	logic [29:0]        pending_values [$];
	int                 mismatch_count = 0;
	int                 holds_asked    = 0;
	int                 holds_done     = 0;
	bit                 calm           = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [5:0] step_pos(input logic [5:0] p);
		if (p >= srg_pkg::TABLE_LEN) begin
			return 6'd1;
		end
		return p + 6'd1;
	endfunction

	// spread fill and four mixing passes from the seed register
	function automatic void rebuild_lag_words();
		longint mag;
		longint folded;
		int     cur;
		int     prev;
		int     t;
		int     pos;
		mag = seed_reg;
		if (mag < 0) begin
			mag = -mag;
		end
		folded = longint'(srg_pkg::SEED_BASE) - mag;
		if (folded < 0) begin
			folded = -folded;
		end
		cur = int'(folded % MOD_INT);
		lag_words[LEN_INT] = cur;
		prev = 1;
		for (int i = 1; i <= LEN_INT - 1; i++) begin
			pos = (21 * i) % LEN_INT;
			lag_words[pos] = prev;
			t = cur - prev;
			if (t < 0) begin
				t += MOD_INT;
			end
			prev = t;
			cur = lag_words[pos];
		end
		for (int pass = 0; pass < 4; pass++) begin
			for (int i = 1; i <= LEN_INT; i++) begin
				t = lag_words[i] - lag_words[1 + (i + 30) % LEN_INT];
				if (t < 0) begin
					t += MOD_INT;
				end
				lag_words[i] = t;
			end
		end
		lead_pos    = 6'd0;
		trail_pos   = srg_pkg::TRAIL_START;
		table_built = 1'b1;
	endfunction

	// one draw, zero draws written back and repeated
	function automatic logic [29:0] next_draw(input bit reseed_bit);
		int d;
		if (!table_built || reseed_bit) begin
			rebuild_lag_words();
		end
		do begin
			lead_pos  = step_pos(lead_pos);
			trail_pos = step_pos(trail_pos);
			d = lag_words[lead_pos] - lag_words[trail_pos];
			if (d < 0) begin
				d += MOD_INT;
			end
			lag_words[lead_pos] = d;
		end while (d == 0);
		return d[29:0];
	endfunction

	// offer one request word, called at a falling edge
	task automatic send_word(input bit rb);
		int gap;
		req_valid <= 1'b1;
		reseed    <= rb;
		do begin
			@(posedge clk);
		end while (req_stall);
		pending_values.push_back(next_draw(rb));
		@(negedge clk);
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// stop offering and wait for every expected value
	task automatic drain();
		req_valid <= 1'b0;
		while (pending_values.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_seed(input logic signed [31:0] v);
		seed_we <= 1'b1;
		seed    <= v;
		@(negedge clk);
		seed_we <= 1'b0;
		seed_reg = v;
	endtask

	// response stall pattern, with one long hold-off on request
	initial begin
		int n_stall;
		int n_free;
		@(negedge clk);
		forever begin
			if (holds_done != holds_asked) begin
				holds_done++;
				n_stall = LONG_HOLD;
			end else begin
				n_stall = pick_gap();
			end
			if ($urandom_range(0, 7) == 0) begin
				n_free = $urandom_range(100, 300);
			end else begin
				n_free = pick_gap() + 1;
			end
			if (n_stall > 0) begin
				rsp_stall <= 1'b1;
				repeat (n_stall) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			repeat (n_free) @(negedge clk);
		end
	end

	// compare each accepted response word with the oldest expectation
	always @(posedge clk) begin
		logic [29:0] want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_values.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected value %0d at %0t", value, $realtime);
				end
			end else begin
				want = pending_values.pop_front();
				if (value !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("value mismatch: expected %0d, got %0d at %0t",
							want, value, $realtime);
					end
				end
			end
		end
	end

	// stimulus
	initial begin
		logic signed [31:0] phase_seed;
		bit                 rb;
		table_built = 1'b0;
		lead_pos    = 6'd0;
		trail_pos   = srg_pkg::TRAIL_START;
		seed_reg    = '0;
		foreach (lag_words[i]) lag_words[i] = 0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (directed_rows[i].load_seed) begin
				drain();
				write_seed(directed_rows[i].seed_val);
			end
			send_word(directed_rows[i].reseed_bit);
		end

		// random phases, each with its own seed
		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			case (p)
				0: phase_seed = 32'sh7fffffff;
				1: phase_seed = 32'sh80000000;
				2: phase_seed = $urandom_range(0, 1000);
				default: phase_seed = $urandom;
			endcase
			write_seed(phase_seed);
			calm = (p == 4 || p == 5);
			if (p == 5) begin
				holds_asked++;
			end
			for (int k = 0; k < PHASE_WORDS; k++) begin
				// phase 3 keeps the old table until a random rebuild
				if (k == 0) begin
					rb = (p != 3);
				end else begin
					rb = ($urandom_range(0, 39) == 0);
				end
				send_word(rb);
			end
		end
		calm = 1'b0;

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_values.size() == 0) begin
			$display("tb_subtractive_random_generator OK");
		end else begin
			$display("tb_subtractive_random_generator NOT OK");
		end
		$finish;
	end

	// run limit
	initial begin
		#40_000_000;
		$display("tb_subtractive_random_generator NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
